// ===== hw/rtl/osur_pkg.sv =====
// shared types and constants of the oversampled uart with receive ring
package osur_pkg;

    localparam int unsigned DATA_W      = 8;
    localparam int unsigned BIT_IDX_W   = 4;
    localparam int unsigned QUEUE_DEPTH = 2;

    // frame positions: start bit is 0, data bits 1..8, stop bit 9
    localparam logic [BIT_IDX_W-1:0] FRAME_STOP = 4'd9;
    localparam logic [BIT_IDX_W-1:0] RX_DONE    = 4'd10;

    // opcode values on the input side
    localparam logic [1:0] OPC_TICK  = 2'd0;
    localparam logic [1:0] OPC_WRITE = 2'd1;
    localparam logic [1:0] OPC_READ  = 2'd2;

    typedef enum logic [3:0] {
        CMD_TICK  = 4'b0001,
        CMD_WRITE = 4'b0010,
        CMD_READ  = 4'b0100,
        CMD_NONE  = 4'b1000
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic              rx_line;
        logic [DATA_W-1:0] tx_byte;
    } cmd_t;

    // packed with tx_line in the lowest bit
    typedef struct packed {
        logic              rx_overflow;
        logic              rx_available;
        logic              read_valid;
        logic [DATA_W-1:0] read_data;
        logic              write_accepted;
        logic              tx_busy;
        logic              tx_line;
    } result_t;

endpackage

// ===== hw/rtl/osur_front.sv =====
// input register that takes words and decodes the opcode into a command
module osur_front
    import osur_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [1:0]   in_opcode,
    input  logic         in_rx_line,
    input  logic [7:0]   in_tx_byte,
    output logic         cmd_valid,
    input  logic         cmd_ready,
    output cmd_t         cmd
);

    logic      valid_reg;
    cmd_t      cmd_reg;
    cmd_t      cmd_next;
    cmd_kind_t kind;

    always_comb
    begin
        unique case (in_opcode)
            OPC_TICK:  kind = CMD_TICK;
            OPC_WRITE: kind = CMD_WRITE;
            OPC_READ:  kind = CMD_READ;
            default:   kind = CMD_NONE;
        endcase
        cmd_next.kind    = kind;
        cmd_next.rx_line = in_rx_line;
        cmd_next.tx_byte = in_tx_byte;
    end

    assign in_ready  = !valid_reg || cmd_ready;
    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

// ===== hw/rtl/osur_queue.sv =====
// two-entry command queue between decode and execution
module osur_queue
    import osur_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_cmd,
    output logic pop_valid,
    input  logic pop_ready,
    output cmd_t pop_cmd
);

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign pop_valid  = (count_reg != '0);
    assign pop        = pop_valid && pop_ready;
    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH)) || pop;
    assign push       = push_valid && push_ready;
    assign pop_cmd    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== hw/rtl/osur_back.sv =====
// execution: transmitter, receiver, receive ring and result register
module osur_back
    import osur_pkg::*;
#(
    parameter int unsigned OVERSAMPLE = 4,
    parameter int unsigned RING_DEPTH = 32
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cmd_valid,
    output logic    cmd_ready,
    input  cmd_t    cmd,
    output logic    res_valid,
    input  logic    res_ready,
    output result_t res
);

    localparam int unsigned CW = $clog2(OVERSAMPLE);
    localparam int unsigned PW = $clog2(RING_DEPTH);
    localparam logic [CW-1:0] TICK_LAST = CW'(OVERSAMPLE - 1);
    localparam logic [CW-1:0] TICK_HALF = CW'(OVERSAMPLE / 2);

    logic [DATA_W-1:0]    tx_shift_reg,  tx_shift_next;
    logic [CW-1:0]        tx_cnt_reg,    tx_cnt_next;
    logic [BIT_IDX_W-1:0] tx_idx_reg,    tx_idx_next;
    logic                 tx_active_reg, tx_active_next;
    logic                 tx_level_reg,  tx_level_next;
    logic [DATA_W-1:0]    rx_shift_reg,  rx_shift_next;
    logic [CW-1:0]        rx_cnt_reg,    rx_cnt_next;
    logic [BIT_IDX_W-1:0] rx_idx_reg,    rx_idx_next;
    logic                 rx_active_reg, rx_active_next;
    logic [PW-1:0]        rd_ptr_reg,    rd_ptr_next;
    logic [PW-1:0]        wr_ptr_reg,    wr_ptr_next;

    logic [DATA_W-1:0]    ring_mem [RING_DEPTH];
    logic [DATA_W-1:0]    rd_data_reg;

    logic                 out_valid_reg;
    result_t              out_reg;
    result_t              out_next;

    logic                 exec;
    logic                 ring_wr;
    logic                 ring_rd;
    logic                 accepted;
    logic                 overflow;
    logic                 popped;

    function automatic logic [PW-1:0] ring_inc(input logic [PW-1:0] p);
        return (p == PW'(RING_DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign exec      = cmd_valid && (!out_valid_reg || res_ready);
    assign cmd_ready = !out_valid_reg || res_ready;

    always_comb
    begin
        tx_shift_next  = tx_shift_reg;
        tx_cnt_next    = tx_cnt_reg;
        tx_idx_next    = tx_idx_reg;
        tx_active_next = tx_active_reg;
        tx_level_next  = tx_level_reg;
        rx_shift_next  = rx_shift_reg;
        rx_cnt_next    = rx_cnt_reg;
        rx_idx_next    = rx_idx_reg;
        rx_active_next = rx_active_reg;
        rd_ptr_next    = rd_ptr_reg;
        wr_ptr_next    = wr_ptr_reg;
        ring_wr        = 1'b0;
        ring_rd        = 1'b0;
        accepted       = 1'b0;
        overflow       = 1'b0;
        popped         = 1'b0;

        unique case (cmd.kind)
            CMD_TICK:
            begin
                // transmitter
                if (tx_active_reg)
                begin
                    if (tx_cnt_reg != TICK_LAST)
                    begin
                        tx_cnt_next = tx_cnt_reg + CW'(1);
                    end
                    else
                    begin
                        tx_cnt_next = '0;
                        if (tx_idx_reg == '0)
                        begin
                            tx_level_next = 1'b0;
                        end
                        else if (tx_idx_reg < FRAME_STOP)
                        begin
                            tx_level_next = tx_shift_reg[0];
                            tx_shift_next = {1'b0, tx_shift_reg[DATA_W-1:1]};
                        end
                        else
                        begin
                            tx_level_next = 1'b1;
                        end
                        if (tx_idx_reg == FRAME_STOP)
                        begin
                            tx_idx_next    = '0;
                            tx_active_next = 1'b0;
                        end
                        else
                        begin
                            tx_idx_next = tx_idx_reg + BIT_IDX_W'(1);
                        end
                    end
                end

                // receiver
                if (!rx_active_reg)
                begin
                    if (!cmd.rx_line)
                    begin
                        rx_cnt_next    = TICK_HALF;
                        rx_active_next = 1'b1;
                        rx_idx_next    = '0;
                    end
                end
                else if (rx_cnt_reg != TICK_LAST)
                begin
                    rx_cnt_next = rx_cnt_reg + CW'(1);
                end
                else
                begin
                    rx_cnt_next = '0;
                    if (rx_idx_reg == '0)
                    begin
                        if (!cmd.rx_line)
                        begin
                            rx_idx_next   = BIT_IDX_W'(1);
                            rx_shift_next = '0;
                        end
                        else
                        begin
                            rx_active_next = 1'b0;
                        end
                    end
                    else if (rx_idx_reg < FRAME_STOP)
                    begin
                        // lsb first: shift in at the top
                        rx_shift_next = {cmd.rx_line, rx_shift_reg[DATA_W-1:1]};
                        rx_idx_next   = rx_idx_reg + BIT_IDX_W'(1);
                    end
                    else if (rx_idx_reg == FRAME_STOP)
                    begin
                        rx_idx_next = RX_DONE;
                    end
                    else
                    begin
                        rx_active_next = 1'b0;
                        if (ring_inc(wr_ptr_reg) == rd_ptr_reg)
                        begin
                            overflow = 1'b1;
                        end
                        else
                        begin
                            ring_wr     = 1'b1;
                            wr_ptr_next = ring_inc(wr_ptr_reg);
                        end
                    end
                end
            end
            CMD_WRITE:
            begin
                if (!tx_active_reg)
                begin
                    tx_shift_next  = cmd.tx_byte;
                    tx_active_next = 1'b1;
                    accepted       = 1'b1;
                end
            end
            CMD_READ:
            begin
                if (rd_ptr_reg != wr_ptr_reg)
                begin
                    ring_rd     = 1'b1;
                    popped      = 1'b1;
                    rd_ptr_next = ring_inc(rd_ptr_reg);
                end
            end
            default:
            begin
            end
        endcase

        out_next.tx_line        = tx_level_next;
        out_next.tx_busy        = tx_active_next;
        out_next.write_accepted = accepted;
        out_next.read_data      = '0;
        out_next.read_valid     = popped;
        out_next.rx_available   = (rd_ptr_next != wr_ptr_next);
        out_next.rx_overflow    = overflow;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_shift_reg  <= '0;
            tx_cnt_reg    <= '0;
            tx_idx_reg    <= '0;
            tx_active_reg <= 1'b0;
            tx_level_reg  <= 1'b1;
            rx_shift_reg  <= '0;
            rx_cnt_reg    <= '0;
            rx_idx_reg    <= '0;
            rx_active_reg <= 1'b0;
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (exec)
            begin
                tx_shift_reg  <= tx_shift_next;
                tx_cnt_reg    <= tx_cnt_next;
                tx_idx_reg    <= tx_idx_next;
                tx_active_reg <= tx_active_next;
                tx_level_reg  <= tx_level_next;
                rx_shift_reg  <= rx_shift_next;
                rx_cnt_reg    <= rx_cnt_next;
                rx_idx_reg    <= rx_idx_next;
                rx_active_reg <= rx_active_next;
                rd_ptr_reg    <= rd_ptr_next;
                wr_ptr_reg    <= wr_ptr_next;
            end
            if (cmd_ready)
            begin
                out_valid_reg <= cmd_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            out_reg <= out_next;
        end
    end

    // ring memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (exec && ring_wr)
        begin
            ring_mem[wr_ptr_reg] <= rx_shift_reg;
        end
        if (exec && ring_rd)
        begin
            rd_data_reg <= ring_mem[rd_ptr_reg];
        end
    end

    assign res_valid = out_valid_reg;

    always_comb
    begin
        res           = out_reg;
        res.read_data = out_reg.read_valid ? rd_data_reg : '0;
    end

endmodule

// ===== hw/rtl/oversampled_uart_with_rx_ring_unit.sv =====
// top level of the oversampled 8n1 uart with receive ring
// Full-duplex 8N1 UART driven by command words: a tick (one period of a clock at
// OVERSAMPLE times the bit rate, carrying the sampled receive pin), a transmit
// write, or a read of the receive ring. Every command word returns exactly one
// status word. Sustained rate is one word per clock while the output is not
// stalled. A command word passes the input register, the command queue and the
// execution register before its status word is driven on the output. The
// execution register is loaded by the execute step, which updates the
// transmitter, receiver and ring pointers together and issues the ring's one
// registered read. The receive ring keeps RING_DEPTH-1 bytes at most; a byte
// that arrives with the ring full is dropped and reported as an overflow. The
// transmitter ignores a write while busy. A failed start bit returns the
// receiver to idle; the stop bit is not checked. The ring needs no clearing
// after reset, so words are taken from the first clock after reset.
module oversampled_uart_with_rx_ring_unit
    import osur_pkg::*;
#(
    parameter int unsigned OVERSAMPLE = 4,
    parameter int unsigned RING_DEPTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [0] rx_line, [8:1] tx_byte, [15:9] zero
    input  logic [15:0] s_axis_tdata,
    // [1:0] opcode
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] tx_line, [1] tx_busy, [2] write_accepted, [10:3] read_data,
    // [11] read_valid, [12] rx_available, [13] rx_overflow, [15:14] zero
    output logic [15:0] m_axis_tdata
);

    // front to queue
    logic    dec_valid;
    logic    dec_ready;
    cmd_t    dec_cmd;

    // queue to back
    logic    exe_valid;
    logic    exe_ready;
    cmd_t    exe_cmd;

    result_t result;

    // decode stage: registers the word and turns the opcode into a command kind
    osur_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_opcode  (s_axis_tuser),
        .in_rx_line (s_axis_tdata[0]),
        .in_tx_byte (s_axis_tdata[8:1]),
        .cmd_valid  (dec_valid),
        .cmd_ready  (dec_ready),
        .cmd        (dec_cmd)
    );

    // short queue so decode keeps taking words while the result side stalls, until it is full
    osur_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (dec_valid),
        .push_ready (dec_ready),
        .push_cmd   (dec_cmd),
        .pop_valid  (exe_valid),
        .pop_ready  (exe_ready),
        .pop_cmd    (exe_cmd)
    );

    // execution: uart state, ring memory and the output register
    osur_back #(
        .OVERSAMPLE (OVERSAMPLE),
        .RING_DEPTH (RING_DEPTH)
    ) u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (exe_valid),
        .cmd_ready  (exe_ready),
        .cmd        (exe_cmd),
        .res_valid  (m_axis_tvalid),
        .res_ready  (m_axis_tready),
        .res        (result)
    );

    // status word padded to two bytes
    assign m_axis_tdata = {2'b00, result};

endmodule
